// ----- design/v3alu_pkg.sv -----
// ============================================================================
// v3alu_pkg
// Shared widths, operation codes, payload types and saturation helpers for
// the three-component vector arithmetic unit.
// ============================================================================
package v3alu_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int TOL_W      = 16;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int SUM_W  = 2 * DATA_WIDTH + 2;
	localparam int SQ_W   = 2 * DATA_WIDTH;
	localparam int Q_W    = FRAC_BITS + 1;
	// input stage, product stage, merge stage, root stages, divide stages, output
	localparam int LAT    = DATA_WIDTH + Q_W + 4;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_NEG   = 3'd2;
	localparam logic [2:0] OP_SCALE = 3'd3;
	localparam logic [2:0] OP_DOT   = 3'd4;
	localparam logic [2:0] OP_CROSS = 3'd5;
	localparam logic [2:0] OP_LEN   = 3'd6;
	localparam logic [2:0] OP_UNIT  = 3'd7;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic  ovf;
		data_t val;
	} sat_t;

	typedef struct packed {
		logic [2:0]  op;
		data_t [2:0] v;
		data_t       s;
		logic        ovf;
		data_t [2:0] a;
	} res_t;

	// drop the fraction bits (floor), then clamp to the data range
	function automatic sat_t sat_sum(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] sh;
		sat_t r;
		sh = x >>> FRAC_BITS;
		if ((&sh[SUM_W-1:DATA_WIDTH-1]) || !(|sh[SUM_W-1:DATA_WIDTH-1])) begin
			r.ovf = 1'b0;
			r.val = sh[DATA_WIDTH-1:0];
		end else begin
			r.ovf = 1'b1;
			r.val = sh[SUM_W-1] ? DATA_MIN : DATA_MAX;
		end
		return r;
	endfunction

	function automatic sat_t sat_add(input logic signed [DATA_WIDTH:0] x);
		sat_t r;
		if (x[DATA_WIDTH] == x[DATA_WIDTH-1]) begin
			r.ovf = 1'b0;
			r.val = x[DATA_WIDTH-1:0];
		end else begin
			r.ovf = 1'b1;
			r.val = x[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
		end
		return r;
	endfunction

endpackage

// ----- design/v3alu_if.sv -----
// ============================================================================
// v3alu request / response channels
// Valid/ready channels carrying one request and one result of the vector unit.
// ============================================================================
interface v3alu_req_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 req_type;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] ax;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] ay;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] az;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] bx;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] by;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] bz;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] factor;

	modport source (output valid, req_type, ax, ay, az, bx, by, bz, factor, input ready);
	modport sink   (input valid, req_type, ax, ay, az, bx, by, bz, factor, output ready);
endinterface

interface v3alu_rsp_if;
	logic                       valid;
	logic                       ready;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] rx;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] ry;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] rz;
	logic signed [v3alu_pkg::DATA_WIDTH-1:0] scalar_result;
	logic                       overflow;

	modport source (output valid, rx, ry, rz, scalar_result, overflow, input ready);
	modport sink   (input valid, rx, ry, rz, scalar_result, overflow, output ready);
endinterface

// ----- design/vector3_alu.sv -----
// ============================================================================
// vector3_alu
// Three-component vector arithmetic unit in signed Q16.16: add, subtract,
// negate, scale, dot, cross, length and unit vector, with saturation.
// ============================================================================
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+------------------------------------------
//  req      | in  | valid/ready   | req_type, ax..az, bx..bz, factor
//  rsp      | out | valid/ready   | rx, ry, rz, scalar_result, overflow
//  cfg      | in  | cfg_we        | cfg_wdata -> zero_tolerance (reset 1)
//
//  One request enters per cycle while the pipeline is not held. Every Q16.16
//  request passes through the input, product and merge stages, the square-root
//  pipeline (one root bit per stage), the unit-vector divider (one quotient bit
//  per stage) and the output register. All operations share the one pipeline,
//  so results leave in request order. The whole pipeline holds while the output
//  register is full and rsp is not ready. Reset clears the stage valid bits
//  and sets zero_tolerance to 1.
//
module vector3_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	v3alu_req_if.sink                     req,
	v3alu_rsp_if.source                   rsp,
	input  logic                          cfg_we,
	input  logic [v3alu_pkg::TOL_W-1:0]   cfg_wdata
);

	localparam int DW  = v3alu_pkg::DATA_WIDTH;
	localparam int QW  = v3alu_pkg::Q_W;
	localparam int LAT = v3alu_pkg::LAT;

	// pipeline control
	logic [LAT-1:0]                vld_q;
	logic                          adv;
	logic [v3alu_pkg::TOL_W-1:0]   tol_q;

	// input stage
	logic [2:0]                    op_s1;
	v3alu_pkg::data_t [2:0]        a_s1;
	v3alu_pkg::data_t [2:0]        b_s1;
	v3alu_pkg::data_t              f_s1;

	// lanes and merge
	logic [2:0]                    lane_op [3];
	v3alu_pkg::data_t [2:0]        lane_a;
	v3alu_pkg::prod_t [2:0]        lane_prod;
	v3alu_pkg::sat_t  [2:0]        lane_vec;
	v3alu_pkg::res_t               res_s3;
	logic [v3alu_pkg::SQ_W-1:0]    sq_s3;

	// after the root
	logic [DW-1:0]                 root;
	v3alu_pkg::res_t               res_rt;
	v3alu_pkg::res_t               res_l;
	logic                          use_unit;

	// divide-stage delay line
	v3alu_pkg::res_t               dres_q [QW];
	logic                          duse_q [QW];
	logic [QW-1:0]                 dq  [3];
	logic                          dneg [3];

	// output register
	v3alu_pkg::data_t [2:0]        rv_q;
	v3alu_pkg::data_t              rs_q;
	logic                          rovf_q;

	// advance whenever the output slot is free or being drained
	assign adv       = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= v3alu_pkg::TOL_W'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= req.req_type;
			a_s1[0] <= req.ax;
			a_s1[1] <= req.ay;
			a_s1[2] <= req.az;
			b_s1[0] <= req.bx;
			b_s1[1] <= req.by;
			b_s1[2] <= req.bz;
			f_s1    <= req.factor;
		end
	end

	// one lane per component; lane i also forms the i-th cross term
	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		v3alu_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.op      (op_s1),
			.a_i     (a_s1[i]),
			.b_i     (b_s1[i]),
			.a_j     (a_s1[J]),
			.b_k     (b_s1[K]),
			.a_k     (a_s1[K]),
			.b_j     (b_s1[J]),
			.f       (f_s1),
			.op_s2   (lane_op[i]),
			.a_s2    (lane_a[i]),
			.prod_s2 (lane_prod[i]),
			.vec     (lane_vec[i])
		);
	end

	v3alu_merge u_merge (
		.clk     (clk),
		.adv     (adv),
		.op_s2   (lane_op[0]),
		.a_s2    (lane_a),
		.prod_s2 (lane_prod),
		.vec     (lane_vec),
		.res_s3  (res_s3),
		.sq_s3   (sq_s3)
	);

	v3alu_sqrt u_sqrt (
		.clk     (clk),
		.adv     (adv),
		.sq      (sq_s3),
		.res_in  (res_s3),
		.root    (root),
		.res_out (res_rt)
	);

	// finish the length, decide whether the unit vector uses the quotient
	always_comb begin
		res_l = res_rt;
		if (res_rt.op == v3alu_pkg::OP_LEN) begin
			if (root[DW-1]) begin
				res_l.s   = v3alu_pkg::DATA_MAX;
				res_l.ovf = 1'b1;
			end else begin
				res_l.s = v3alu_pkg::data_t'(root);
			end
		end
		use_unit = (res_rt.op == v3alu_pkg::OP_UNIT) && (root > DW'(tol_q));
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3alu_div u_div (
			.clk (clk),
			.adv (adv),
			.a   (res_rt.a[i]),
			.l   (root),
			.q   (dq[i]),
			.neg (dneg[i])
		);
	end

	// hold the other results in step with the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			dres_q[0] <= res_l;
			duse_q[0] <= use_unit;
			for (int k = 1; k < QW; k++) begin
				dres_q[k] <= dres_q[k-1];
				duse_q[k] <= duse_q[k-1];
			end
		end
	end

	// output register: restore the sign of each quotient for unit vectors
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (duse_q[QW-1]) begin
					rv_q[i] <= dneg[i] ? -v3alu_pkg::data_t'(DW'(dq[i]))
						: v3alu_pkg::data_t'(DW'(dq[i]));
				end else begin
					rv_q[i] <= dres_q[QW-1].v[i];
				end
			end
			rs_q   <= dres_q[QW-1].s;
			rovf_q <= dres_q[QW-1].ovf;
		end
	end

	assign rsp.valid         = vld_q[LAT-1];
	assign rsp.rx            = rv_q[0];
	assign rsp.ry            = rv_q[1];
	assign rsp.rz            = rv_q[2];
	assign rsp.scalar_result = rs_q;
	assign rsp.overflow      = rovf_q;

endmodule

// ----- design/v3alu_lane.sv -----
// ============================================================================
// v3alu_lane
// One component lane: two multipliers and the saturating add/sub/negate,
// registered, plus the vector result formed from these registered values.
// ============================================================================
module v3alu_lane (
	input  logic                clk,
	input  logic                adv,
	input  logic [2:0]          op,
	input  v3alu_pkg::data_t    a_i,
	input  v3alu_pkg::data_t    b_i,
	input  v3alu_pkg::data_t    a_j,
	input  v3alu_pkg::data_t    b_k,
	input  v3alu_pkg::data_t    a_k,
	input  v3alu_pkg::data_t    b_j,
	input  v3alu_pkg::data_t    f,
	output logic [2:0]          op_s2,
	output v3alu_pkg::data_t    a_s2,
	output v3alu_pkg::prod_t    prod_s2,
	output v3alu_pkg::sat_t     vec
);

	v3alu_pkg::data_t  m1x, m1y;
	v3alu_pkg::sat_t   ew;
	logic signed [v3alu_pkg::DATA_WIDTH:0] ae, be;
	v3alu_pkg::prod_t  p2_s2;
	v3alu_pkg::sat_t   ew_s2;
	logic signed [v3alu_pkg::SUM_W-1:0] e1, e2;

	always_comb begin
		m1x = a_i;
		m1y = a_i;
		case (op)
			v3alu_pkg::OP_SCALE: m1y = f;
			v3alu_pkg::OP_DOT:   m1y = b_i;
			v3alu_pkg::OP_CROSS: begin
				m1x = a_j;
				m1y = b_k;
			end
			default: m1y = a_i;
		endcase
	end

	always_comb begin
		ae = {a_i[v3alu_pkg::DATA_WIDTH-1], a_i};
		be = {b_i[v3alu_pkg::DATA_WIDTH-1], b_i};
		case (op)
			v3alu_pkg::OP_ADD: ew = v3alu_pkg::sat_add(ae + be);
			v3alu_pkg::OP_SUB: ew = v3alu_pkg::sat_add(ae - be);
			v3alu_pkg::OP_NEG: ew = v3alu_pkg::sat_add(-ae);
			default:           ew = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op;
			a_s2    <= a_i;
			ew_s2   <= ew;
			prod_s2 <= v3alu_pkg::prod_t'(m1x) * v3alu_pkg::prod_t'(m1y);
			p2_s2   <= v3alu_pkg::prod_t'(a_k) * v3alu_pkg::prod_t'(b_j);
		end
	end

	always_comb begin
		e1 = v3alu_pkg::SUM_W'(prod_s2);
		e2 = v3alu_pkg::SUM_W'(p2_s2);
		case (op_s2)
			v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_NEG: vec = ew_s2;
			v3alu_pkg::OP_SCALE: vec = v3alu_pkg::sat_sum(e1);
			v3alu_pkg::OP_CROSS: vec = v3alu_pkg::sat_sum(e1 - e2);
			default:             vec = '0;
		endcase
	end

endmodule

// ----- design/v3alu_merge.sv -----
// ============================================================================
// v3alu_merge
// Combine the three lanes: sum products for dot and squared length, collect
// the vector result and the overflow flag.
// ============================================================================
module v3alu_merge (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [2:0]                 op_s2,
	input  v3alu_pkg::data_t [2:0]     a_s2,
	input  v3alu_pkg::prod_t [2:0]     prod_s2,
	input  v3alu_pkg::sat_t  [2:0]     vec,
	output v3alu_pkg::res_t            res_s3,
	output logic [v3alu_pkg::SQ_W-1:0] sq_s3
);

	logic signed [v3alu_pkg::SUM_W-1:0] sum;
	v3alu_pkg::sat_t dot;
	v3alu_pkg::res_t res;

	always_comb begin
		sum = v3alu_pkg::SUM_W'(prod_s2[0]) + v3alu_pkg::SUM_W'(prod_s2[1])
			+ v3alu_pkg::SUM_W'(prod_s2[2]);
		dot = v3alu_pkg::sat_sum(sum);
		res.op  = op_s2;
		res.a   = a_s2;
		res.v[0] = vec[0].val;
		res.v[1] = vec[1].val;
		res.v[2] = vec[2].val;
		res.ovf = vec[0].ovf | vec[1].ovf | vec[2].ovf;
		res.s   = '0;
		if (op_s2 == v3alu_pkg::OP_DOT) begin
			res.s   = dot.val;
			res.ovf = dot.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res;
			sq_s3  <= sum[v3alu_pkg::SQ_W-1:0];
		end
	end

endmodule

// ----- design/v3alu_sqrt.sv -----
// ============================================================================
// v3alu_sqrt
// Pipelined integer square root, one root bit per stage, most significant
// first; the request payload travels alongside.
// ============================================================================
module v3alu_sqrt (
	input  logic                             clk,
	input  logic                             adv,
	input  logic [v3alu_pkg::SQ_W-1:0]       sq,
	input  v3alu_pkg::res_t                  res_in,
	output logic [v3alu_pkg::DATA_WIDTH-1:0] root,
	output v3alu_pkg::res_t                  res_out
);

	localparam int DW = v3alu_pkg::DATA_WIDTH;
	localparam int SW = v3alu_pkg::SQ_W;

	logic [SW-1:0]   rem_q  [DW];
	logic [DW-1:0]   root_q [DW];
	v3alu_pkg::res_t res_q  [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		localparam int B = DW - 1 - k;
		logic [SW-1:0]   rem_p, rem_n;
		logic [DW-1:0]   root_p, root_n;
		v3alu_pkg::res_t res_p;
		logic [SW:0]     trial;

		if (k == 0) begin : g_first
			assign rem_p  = sq;
			assign root_p = '0;
			assign res_p  = res_in;
		end else begin : g_next
			assign rem_p  = rem_q[k-1];
			assign root_p = root_q[k-1];
			assign res_p  = res_q[k-1];
		end

		always_comb begin
			// (r + 2^B)^2 - r^2
			trial  = ((SW+1)'(root_p) << (B + 1)) + ((SW+1)'(1) << (2 * B));
			rem_n  = rem_p;
			root_n = root_p;
			if ({1'b0, rem_p} >= trial) begin
				rem_n  = rem_p - trial[SW-1:0];
				root_n = root_p | (DW'(1) << B);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k]  <= rem_n;
				root_q[k] <= root_n;
				res_q[k]  <= res_p;
			end
		end
	end

	assign root    = root_q[DW-1];
	assign res_out = res_q[DW-1];

endmodule

// ----- design/v3alu_div.sv -----
// ============================================================================
// v3alu_div
// Pipelined restoring divider for one unit-vector component:
// (|a| * 2^FRAC_BITS) / l, one quotient bit per stage.
// ============================================================================
module v3alu_div (
	input  logic                             clk,
	input  logic                             adv,
	input  v3alu_pkg::data_t                 a,
	input  logic [v3alu_pkg::DATA_WIDTH-1:0] l,
	output logic [v3alu_pkg::Q_W-1:0]        q,
	output logic                             neg
);

	localparam int DW = v3alu_pkg::DATA_WIDTH;
	localparam int QW = v3alu_pkg::Q_W;

	logic [DW-1:0] r_q   [QW];
	logic [QW-1:0] q_q   [QW];
	logic          neg_q [QW];
	logic [DW-1:0] l_q   [QW];

	logic [DW-1:0] mag;
	logic          q0;

	always_comb begin
		mag = a[DW-1] ? DW'(-a) : DW'(a);
		q0  = (mag >= l);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_q[0]   <= q0 ? (mag - l) : mag;
			q_q[0]   <= QW'(q0);
			neg_q[0] <= a[DW-1];
			l_q[0]   <= l;
		end
	end

	for (genvar k = 1; k < QW; k++) begin : g_step
		logic [DW:0] r2;
		logic        bit_n;

		always_comb begin
			r2    = {r_q[k-1], 1'b0};
			bit_n = (r2 >= {1'b0, l_q[k-1]});
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				r_q[k]   <= bit_n ? DW'(r2 - {1'b0, l_q[k-1]}) : r2[DW-1:0];
				q_q[k]   <= {q_q[k-1][QW-2:0], bit_n};
				neg_q[k] <= neg_q[k-1];
				l_q[k]   <= l_q[k-1];
			end
		end
	end

	assign q   = q_q[QW-1];
	assign neg = neg_q[QW-1];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: vector3_alu testbench
// Drives requests through the valid/ready request channel and checks each
// result against an in-bench fixed-point predictor, in order. Covers every
// operation, saturation corners, zero-tolerance settings and backpressure.
// ============================================================================
module tb_top;
	import v3alu_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [2:0] op;
		data_t      ax, ay, az, bx, by, bz, factor;
	} vec_request_t;

	typedef struct {
		data_t rx, ry, rz, sres;
		logic  ovf;
	} vec_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [TOL_W-1:0] cfg_wdata;

	v3alu_req_if req_ch ();
	v3alu_rsp_if rsp_ch ();

	vector3_alu DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch.sink),
		.rsp      (rsp_ch.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of the tolerance register
	logic [TOL_W-1:0] tolerance_shadow;
	vec_result_t      pending_results[$];
	int               error_count;
	int               result_count;
	int               request_count;
	int               cycle_count = 0;
	int               op_seen[8];

	// idling controls for the sender and the receiver
	bit quiet_mode;   // no random idling on either side
	bit hold_start;   // ask the receiver for one long hold-off

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("vector3_alu: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	// clamp a wide signed value to the data range, flagging any clipping
	function automatic data_t clamp_data(input logic signed [127:0] x, inout logic ovf);
		if (x > 128'sh7FFFFFFF) begin
			ovf = 1'b1;
			return DATA_MAX;
		end
		if (x < -128'sh80000000) begin
			ovf = 1'b1;
			return DATA_MIN;
		end
		return x[DATA_WIDTH-1:0];
	endfunction

	// floor square root of a non-negative value, one root bit per step
	function automatic logic [127:0] floor_root(input logic [127:0] s);
		logic [127:0] r;
		logic [127:0] t;
		r = '0;
		for (int b = 56; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (t * t <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic vec_result_t predict_result(input vec_request_t q,
		input logic [TOL_W-1:0] tol);
		logic signed [127:0] a[3];
		logic signed [127:0] b[3];
		logic signed [127:0] f;
		logic signed [127:0] acc;
		logic [127:0]        len;
		logic [127:0]        mag;
		logic [127:0]        quo;
		data_t               v[3];
		vec_result_t         r;
		logic                ovf;
		a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
		b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
		f = q.factor;
		v[0] = '0; v[1] = '0; v[2] = '0;
		ovf = 1'b0;
		r.sres = '0;
		case (q.op)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) v[i] = clamp_data(a[i] + b[i], ovf);
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) v[i] = clamp_data(a[i] - b[i], ovf);
			end
			OP_NEG: begin
				for (int i = 0; i < 3; i++) v[i] = clamp_data(-a[i], ovf);
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++)
					v[i] = clamp_data((a[i] * f) >>> FRAC_BITS, ovf);
			end
			OP_DOT: begin
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				r.sres = clamp_data(acc >>> FRAC_BITS, ovf);
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					acc = a[(i + 1) % 3] * b[(i + 2) % 3] - a[(i + 2) % 3] * b[(i + 1) % 3];
					v[i] = clamp_data(acc >>> FRAC_BITS, ovf);
				end
			end
			default: begin
				len = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
				if (q.op == OP_LEN) begin
					r.sres = clamp_data($signed(len), ovf);
				end else if (len > tol) begin
					// each component is |a| / len in Q16.16, truncated, sign restored
					for (int i = 0; i < 3; i++) begin
						mag = (a[i] < 0) ? -a[i] : a[i];
						quo = (mag << FRAC_BITS) / len;
						if (a[i] < 0)
							quo = -quo;
						v[i] = quo[DATA_WIDTH-1:0];
					end
				end
			end
		endcase
		r.rx = v[0];
		r.ry = v[1];
		r.rz = v[2];
		r.ovf = ovf;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result checking: compare every accepted result with the oldest prediction
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] ERROR result %0d: %s", $realtime, result_count, what);
	endtask

	always @(posedge clk) begin
		vec_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.rx !== want.rx)
					report_mismatch($sformatf("rx %h, want %h", rsp_ch.rx, want.rx));
				if (rsp_ch.ry !== want.ry)
					report_mismatch($sformatf("ry %h, want %h", rsp_ch.ry, want.ry));
				if (rsp_ch.rz !== want.rz)
					report_mismatch($sformatf("rz %h, want %h", rsp_ch.rz, want.rz));
				if (rsp_ch.scalar_result !== want.sres)
					report_mismatch($sformatf("scalar %h, want %h",
						rsp_ch.scalar_result, want.sres));
				if (rsp_ch.overflow !== want.ovf)
					report_mismatch($sformatf("overflow %b, want %b",
						rsp_ch.overflow, want.ovf));
			end
			result_count++;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, quiet stretches, and one long hold-off on demand
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				// hold ready low so the pipeline backs up into the request side
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (quiet_mode) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= 20);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------
	// Present one request, hold it until accepted, then log its prediction.
	// Valid stays high on return so back-to-back requests need no extra edge.
	task automatic send_request(input vec_request_t q);
		if (!quiet_mode && $urandom_range(0, 99) < 20) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= q.op;
		req_ch.ax       <= q.ax;
		req_ch.ay       <= q.ay;
		req_ch.az       <= q.az;
		req_ch.bx       <= q.bx;
		req_ch.by       <= q.by;
		req_ch.bz       <= q.bz;
		req_ch.factor   <= q.factor;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_result(q, tolerance_shadow));
		op_seen[q.op]++;
		request_count++;
	endtask

	// drop valid and wait for the pipeline to drain completely
	task automatic drain_pipeline();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	// write the tolerance register; only called with the pipeline drained
	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tolerance_shadow = value;
	endtask

	function automatic vec_request_t make_request(input logic [2:0] op,
		input data_t ax, ay, az, bx, by, bz, factor);
		vec_request_t q;
		q.op = op;
		q.ax = ax; q.ay = ay; q.az = az;
		q.bx = bx; q.by = by; q.bz = bz;
		q.factor = factor;
		return q;
	endfunction

	// component value biased toward corners, small magnitudes and tiny vectors
	function automatic data_t random_component();
		case ($urandom_range(0, 7))
			0, 1:    return $urandom;
			2:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			3:       return $signed($urandom_range(0, 400)) - 200;
			4:       return DATA_MAX - $urandom_range(0, 3);
			5:       return DATA_MIN + $urandom_range(0, 3);
			6:       return ($urandom_range(0, 1) ? 1 : -1) * (1 << FRAC_BITS);
			default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
		endcase
	endfunction

	function automatic vec_request_t random_request();
		return make_request(3'($urandom_range(0, 7)), random_component(),
			random_component(), random_component(), random_component(),
			random_component(), random_component(), random_component());
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		data_t one;
		one = 1 << FRAC_BITS;
		quiet_mode = 1'b1;
		send_request(make_request(OP_ADD, DATA_MAX, DATA_MIN, 5, DATA_MAX, DATA_MIN, -5, 0));
		send_request(make_request(OP_SUB, DATA_MIN, DATA_MAX, 0, DATA_MAX, DATA_MIN, 0, 0));
		send_request(make_request(OP_NEG, DATA_MIN, DATA_MAX, 0, 0, 0, 0, 0));
		send_request(make_request(OP_SCALE, DATA_MAX, DATA_MIN, -one, 0, 0, 0, DATA_MAX));
		send_request(make_request(OP_SCALE, DATA_MIN, 3, -3, 0, 0, 0, DATA_MIN));
		send_request(make_request(OP_SCALE, DATA_MAX, -7, one, 0, 0, 0, 0));
		// floor on negative products
		send_request(make_request(OP_SCALE, -1, 1, -3, 0, 0, 0, 1));
		send_request(make_request(OP_DOT, DATA_MAX, DATA_MAX, DATA_MAX,
			DATA_MAX, DATA_MAX, DATA_MAX, 0));
		send_request(make_request(OP_DOT, DATA_MIN, DATA_MIN, DATA_MIN,
			DATA_MAX, DATA_MAX, DATA_MAX, 0));
		send_request(make_request(OP_DOT, one, 2 * one, -one, 3 * one, one, one, 0));
		send_request(make_request(OP_CROSS, one, 0, 0, 0, one, 0, 0));
		send_request(make_request(OP_CROSS, DATA_MAX, DATA_MIN, DATA_MAX,
			DATA_MIN, DATA_MAX, DATA_MIN, 0));
		send_request(make_request(OP_LEN, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_LEN, 3 * one, 4 * one, 0, 0, 0, 0, 0));
		send_request(make_request(OP_LEN, DATA_MIN, DATA_MIN, DATA_MIN, 0, 0, 0, 0));
		// unit: zero vector, length equal to tolerance, just above it
		send_request(make_request(OP_UNIT, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_UNIT, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_UNIT, -2, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_UNIT, 3 * one, -4 * one, 0, 0, 0, 0, 0));
		send_request(make_request(OP_UNIT, DATA_MIN, DATA_MAX, DATA_MIN, 0, 0, 0, 0));
		send_request(make_request(OP_UNIT, DATA_MAX, 0, 0, 0, 0, 0, 0));
		drain_pipeline();
		quiet_mode = 1'b0;
	endtask

	// sweep tolerance settings with short vectors around each threshold
	task automatic test_tolerance();
		logic [TOL_W-1:0] settings[4];
		data_t            c;
		settings[0] = 16'h0000;
		settings[1] = 16'hFFFF;
		settings[2] = 16'h0100;
		settings[3] = 16'($urandom_range(2, 16'hFFFE));
		foreach (settings[s]) begin
			write_tolerance(settings[s]);
			for (int i = 0; i < 20; i++) begin
				c = data_t'(settings[s]) + data_t'($urandom_range(0, 4)) - 2;
				send_request(make_request($urandom_range(0, 1) ? OP_UNIT : OP_LEN,
					$urandom_range(0, 1) ? c : -c, $signed($urandom_range(0, 6)) - 3,
					$urandom_range(0, 2) == 0 ? c : 0, 0, 0, 0, 0));
			end
			drain_pipeline();
		end
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			// long stretch with no idling in the middle of the run
			quiet_mode = (i >= count / 3) && (i < count / 3 + 200);
			send_request(random_request());
		end
		quiet_mode = 1'b0;
	endtask

	// receiver holds off while requests keep coming so the input stalls
	task automatic test_backpressure();
		hold_start = 1'b1;
		for (int i = 0; i < 150; i++) send_request(random_request());
		drain_pipeline();
	endtask

	initial begin
		error_count      = 0;
		result_count     = 0;
		request_count    = 0;
		quiet_mode       = 1'b0;
		hold_start       = 1'b0;
		tolerance_shadow = 16'h0001;
		foreach (op_seen[i]) op_seen[i] = 0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= OP_ADD;
		req_ch.ax        <= '0;
		req_ch.ay        <= '0;
		req_ch.az        <= '0;
		req_ch.bx        <= '0;
		req_ch.by        <= '0;
		req_ch.bz        <= '0;
		req_ch.factor    <= '0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		repeat (2) @(posedge clk);

		test_directed();
		test_tolerance();
		write_tolerance(16'h0001);
		test_random(650);
		// pause until every outstanding result is back
		drain_pipeline();
		test_backpressure();
		write_tolerance(16'($urandom_range(0, 16'hFFFF)));
		test_random(650);
		drain_pipeline();

		$display("covered %0d requests and %0d results across all eight operations",
			request_count, result_count);
		$display("ops add/sub/neg/scale/dot/cross/len/unit: %0d %0d %0d %0d %0d %0d %0d %0d",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3],
			op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("vector3_alu: match");
		end else begin
			$display("vector3_alu: mismatch");
		end
		$finish;
	end

endmodule
